// ===== design/pbpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pbpc_pkg;

    // Width of the saturating byte counter within a frame.
    localparam int POSITION_BITS = 16;
    localparam int POS_EXT_BITS  = POSITION_BITS + 1;

    // Frame layout.
    localparam int MAC_BYTES     = 14;
    localparam int V6_HEADER     = 40;
    localparam int MIN_FRAME_POS = MAC_BYTES + 20 - 1;
    localparam int V6_PROTO_POS  = MAC_BYTES + 6;
    localparam int V4_PROTO_POS  = MAC_BYTES + 9;
    localparam logic [3:0] IHL_MASK = 4'h0F;

    // IP versions and transport protocols.
    localparam logic [3:0] IP_VERSION_4 = 4'd4;
    localparam logic [3:0] IP_VERSION_6 = 4'd6;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_SCTP   = 8'd132;

    // Well-known ports.
    localparam logic [15:0] PORT_HTTP     = 16'd80;
    localparam logic [15:0] PORT_HTTPS    = 16'd443;
    localparam logic [15:0] PORT_DIAMETER = 16'd3868;
    localparam logic [15:0] PORT_GTPC     = 16'd2123;
    localparam logic [15:0] PORT_GTPU     = 16'd2152;
    localparam logic [15:0] PORT_SIP      = 16'd5060;
    localparam logic [15:0] PORT_SIPS     = 16'd5061;
    localparam logic [15:0] PORT_DNS      = 16'd53;

    // Reset values of the RTP range.
    localparam logic [15:0] RTP_LOW_RESET  = 16'd10000;
    localparam logic [15:0] RTP_HIGH_RESET = 16'd20000;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RTP_LOW  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RTP_HIGH = 2'd1;

    // Traffic class codes.
    typedef enum logic [3:0] {
        CLS_UNKNOWN  = 4'd0,
        CLS_TCP      = 4'd1,
        CLS_UDP      = 4'd2,
        CLS_SCTP     = 4'd3,
        CLS_HTTP     = 4'd4,
        CLS_HTTPS    = 4'd5,
        CLS_DIAMETER = 4'd6,
        CLS_GTPC     = 4'd7,
        CLS_GTPU     = 4'd8,
        CLS_SIP      = 4'd9,
        CLS_RTP      = 4'd10,
        CLS_DNS      = 4'd11
    } class_t;

    // What the parser hands to the classifier for one finished frame.
    typedef struct packed {
        logic        frame_ok;
        logic [7:0]  proto;
        logic        tl_ge4;
        logic        tl_ge8;
        logic        tl_ge20;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } summary_t;

    // Status of the summary queue head toward the classifier.
    typedef struct packed {
        logic valid;
    } link_t;

endpackage

`default_nettype wire

// ===== design/pbpc_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbpc_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic              sum_full,
    input  wire logic [7:0]        frame_byte,
    input  wire logic              frame_end,
    output logic                   sum_push,
    output pbpc_pkg::summary_t     sum_data
);
    import pbpc_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [3:0]               ver_reg, ver_next;
    logic [5:0]               hdr_reg, hdr_next;
    logic [7:0]               proto_reg, proto_next;
    logic [15:0]              src_reg, src_next;
    logic [15:0]              dst_reg, dst_next;

    logic                     accept;
    logic                     at_ip_start;
    logic [POS_EXT_BITS-1:0]  pos_ext;
    logic [POS_EXT_BITS-1:0]  hdr_ext;
    logic [POS_EXT_BITS-1:0]  port_start;
    logic [POS_EXT_BITS-1:0]  port_rel;
    logic                     in_ports;

    assign accept      = push && !sum_full;
    assign at_ip_start = (pos_reg == POSITION_BITS'(MAC_BYTES));
    assign pos_ext     = {1'b0, pos_reg};

    // Header fields, including what the current byte writes.
    always_comb
    begin
        ver_next   = ver_reg;
        hdr_next   = hdr_reg;
        proto_next = proto_reg;
        if (at_ip_start)
        begin
            ver_next = frame_byte[7:4];
            if (frame_byte[7:4] == IP_VERSION_6)
                hdr_next = 6'(V6_HEADER);
            else
                hdr_next = {frame_byte[3:0] & IHL_MASK, 2'b00};
        end
        if ((pos_reg == POSITION_BITS'(V6_PROTO_POS) && ver_reg == IP_VERSION_6) ||
            (pos_reg == POSITION_BITS'(V4_PROTO_POS) && ver_reg == IP_VERSION_4))
            proto_next = frame_byte;
    end

    // Transport port capture over the first four transport bytes.
    always_comb
    begin
        hdr_ext    = POS_EXT_BITS'(hdr_next);
        port_start = POS_EXT_BITS'(MAC_BYTES) + hdr_ext;
        port_rel   = pos_ext - port_start;
        in_ports   = (pos_ext >= port_start) && (port_rel < POS_EXT_BITS'(4));
        src_next   = src_reg;
        dst_next   = dst_reg;
        if (in_ports)
        begin
            unique case (port_rel[1:0])
                2'd0:    src_next = {frame_byte, src_reg[7:0]};
                2'd1:    src_next = {src_reg[15:8], frame_byte};
                2'd2:    dst_next = {frame_byte, dst_reg[7:0]};
                default: dst_next = {dst_reg[15:8], frame_byte};
            endcase
        end
    end

    // Frame summary; the transport length is the frame length less MAC and IP headers.
    always_comb
    begin
        sum_data.frame_ok    = (pos_ext >= POS_EXT_BITS'(MIN_FRAME_POS)) &&
                               (ver_next == IP_VERSION_4 || ver_next == IP_VERSION_6);
        sum_data.proto       = proto_next;
        sum_data.tl_ge4      = pos_ext >= hdr_ext + POS_EXT_BITS'(MAC_BYTES + 3);
        sum_data.tl_ge8      = pos_ext >= hdr_ext + POS_EXT_BITS'(MAC_BYTES + 7);
        sum_data.tl_ge20     = pos_ext >= hdr_ext + POS_EXT_BITS'(MAC_BYTES + 19);
        sum_data.source_port = src_next;
        sum_data.dest_port   = dst_next;
    end

    assign sum_push = accept && frame_end;

    // Frame state; everything clears after the last byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            ver_reg   <= '0;
            hdr_reg   <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                pos_reg   <= '0;
                ver_reg   <= '0;
                hdr_reg   <= '0;
                proto_reg <= '0;
                src_reg   <= '0;
                dst_reg   <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                ver_reg   <= ver_next;
                hdr_reg   <= hdr_next;
                proto_reg <= proto_next;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
            end
        end
    end

    // Saturating byte counter.
    assign pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POSITION_BITS'(1);

endmodule

`default_nettype wire

// ===== design/pbpc_summary_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbpc_summary_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire pbpc_pkg::summary_t wr_data,
    output logic                    full,
    output pbpc_pkg::link_t         rd_link_out,
    input  wire logic               rd_en,
    output pbpc_pkg::summary_t      rd_data
);
    import pbpc_pkg::*;

    summary_t    mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        do_wr;
    logic        do_rd;

    assign full              = (count_reg == 2'd2);
    assign rd_link_out.valid = (count_reg != 2'd0);
    assign do_wr             = wr_en && !full;
    assign do_rd             = rd_en && rd_link_out.valid;
    assign rd_data           = mem[rd_ptr_reg];

    // Occupancy after this cycle's transactions.
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 2'd1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 2'd1;
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// ===== design/pbpc_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbpc_classifier (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire pbpc_pkg::link_t                     head_link,
    input  wire pbpc_pkg::summary_t                  head_data,
    output logic                                     head_pop,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pbpc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [15:0]                         cfg_data,
    input  wire logic                                pop,
    output logic                                     empty,
    output logic [3:0]                               traffic_class,
    output logic                                     ports_found,
    output logic [15:0]                              source_port_out,
    output logic [15:0]                              dest_port_out
);
    import pbpc_pkg::*;

    logic [15:0] rtp_low_reg;
    logic [15:0] rtp_high_reg;
    logic        out_valid_reg;
    class_t      class_reg, class_next;
    logic        found_reg, found_next;
    logic [15:0] src_reg, dst_reg;
    logic        load;
    logic [15:0] s;
    logic [15:0] d;

    assign cfg_ready = 1'b1;
    assign s         = head_data.source_port;
    assign d         = head_data.dest_port;

    // Take the next summary when the output register is free or being drained.
    assign load     = head_link.valid && (!out_valid_reg || pop);
    assign head_pop = load;

    // Class decision from protocol, transport length and ports.
    always_comb
    begin
        class_next = CLS_UNKNOWN;
        found_next = 1'b0;
        if (head_data.frame_ok)
        begin
            if (head_data.proto == PROTO_TCP || head_data.proto == PROTO_UDP ||
                head_data.proto == PROTO_SCTP)
                found_next = head_data.tl_ge4;
            if (head_data.proto == PROTO_TCP)
            begin
                class_next = CLS_TCP;
                if (head_data.tl_ge20)
                begin
                    priority if (s == PORT_HTTP || d == PORT_HTTP)
                        class_next = CLS_HTTP;
                    else if (s == PORT_HTTPS || d == PORT_HTTPS)
                        class_next = CLS_HTTPS;
                    else if (s == PORT_DIAMETER || d == PORT_DIAMETER)
                        class_next = CLS_DIAMETER;
                    else
                        class_next = CLS_TCP;
                end
            end
            else if (head_data.proto == PROTO_UDP)
            begin
                class_next = CLS_UDP;
                if (head_data.tl_ge8)
                begin
                    priority if (s == PORT_GTPC || d == PORT_GTPC)
                        class_next = CLS_GTPC;
                    else if (s == PORT_GTPU || d == PORT_GTPU)
                        class_next = CLS_GTPU;
                    else if (s == PORT_SIP || d == PORT_SIP ||
                             s == PORT_SIPS || d == PORT_SIPS)
                        class_next = CLS_SIP;
                    else if ((s >= rtp_low_reg && s <= rtp_high_reg) ||
                             (d >= rtp_low_reg && d <= rtp_high_reg))
                        class_next = CLS_RTP;
                    else if (s == PORT_DNS || d == PORT_DNS)
                        class_next = CLS_DNS;
                    else
                        class_next = CLS_UDP;
                end
            end
            else if (head_data.proto == PROTO_SCTP)
            begin
                class_next = CLS_SCTP;
            end
        end
    end

    // Configuration registers; unused indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rtp_low_reg  <= RTP_LOW_RESET;
            rtp_high_reg <= RTP_HIGH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_RTP_LOW)
                rtp_low_reg <= cfg_data;
            else if (cfg_index == CFG_RTP_HIGH)
                rtp_high_reg <= cfg_data;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            class_reg <= class_next;
            found_reg <= found_next;
            src_reg   <= found_next ? s : 16'd0;
            dst_reg   <= found_next ? d : 16'd0;
        end
    end

    assign empty           = !out_valid_reg;
    assign traffic_class   = class_reg;
    assign ports_found     = found_reg;
    assign source_port_out = src_reg;
    assign dest_port_out   = dst_reg;

endmodule

`default_nettype wire

// ===== design/port_based_packet_classifier_core.sv =====
// Throughput: one frame byte per cycle while full is low; one result per cycle may be taken
// at the output. A frame's summary passes through the queue into the output register.
// A two-entry summary queue sits between the byte parser and the classifier output register.
// Reset (rst_n low, asynchronous) clears the byte counter, header fields, queue and output
// valid, and sets the RTP range to 10000 through 20000.
`timescale 1ns / 1ps
`default_nettype none

module port_based_packet_classifier_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [7:0]                          frame_byte,
    input  wire logic                                frame_end,
    input  wire logic                                pop,
    output logic                                     empty,
    output logic [3:0]                               traffic_class,
    output logic                                     ports_found,
    output logic [15:0]                              source_port_out,
    output logic [15:0]                              dest_port_out,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pbpc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [15:0]                         cfg_data
);
    import pbpc_pkg::*;

    logic     sum_push;
    summary_t sum_wr;
    summary_t sum_rd;
    link_t    sum_link;
    logic     sum_pop;

    // Front: byte parser.
    pbpc_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .sum_full   (full),
        .frame_byte (frame_byte),
        .frame_end  (frame_end),
        .sum_push   (sum_push),
        .sum_data   (sum_wr)
    );

    // Queue of finished frame summaries.
    pbpc_summary_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (sum_push),
        .wr_data     (sum_wr),
        .full        (full),
        .rd_link_out (sum_link),
        .rd_en       (sum_pop),
        .rd_data     (sum_rd)
    );

    // Back: classifier and output register.
    pbpc_classifier u_classifier (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_link       (sum_link),
        .head_data       (sum_rd),
        .head_pop        (sum_pop),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pop             (pop),
        .empty           (empty),
        .traffic_class   (traffic_class),
        .ports_found     (ports_found),
        .source_port_out (source_port_out),
        .dest_port_out   (dest_port_out)
    );

endmodule

`default_nettype wire

// ===== design/pbpc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbpc_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pop,
    input  wire logic        empty,
    input  wire logic [3:0]  traffic_class,
    input  wire logic        ports_found,
    input  wire logic [15:0] source_port_out,
    input  wire logic [15:0] dest_port_out
);
    import pbpc_pkg::*;

    // A waiting result holds until its transaction completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(traffic_class) &&
                              $stable(ports_found) && $stable(source_port_out) &&
                              $stable(dest_port_out)))
        else $error("result changed while waiting");

    // Class codes stay within the defined set.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (traffic_class <= CLS_DNS))
        else $error("class code out of range");

    // Ports read as zero when none were found.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !ports_found) |-> (source_port_out == 16'd0 && dest_port_out == 16'd0))
        else $error("ports not zero without ports_found");

    // Found ports imply a known transport class.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && ports_found) |-> (traffic_class != CLS_UNKNOWN))
        else $error("ports found on unknown class");

endmodule

bind port_based_packet_classifier_core pbpc_checker u_pbpc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop             (pop),
    .empty           (empty),
    .traffic_class   (traffic_class),
    .ports_found     (ports_found),
    .source_port_out (source_port_out),
    .dest_port_out   (dest_port_out)
);

`default_nettype wire
